@@ design/sphit_pkg.sv @@
// Shared types and constants for the swept point / box earliest hit block.
// Used by sphit_div, sphit_ctrl, sphit_dp and the top level.
package sphit_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int TIME_FRAC_BITS  = 16;

  localparam int COORD_W   = 32;
  localparam int HIT_TIME_W = 17;
  localparam int NUM_AXES  = 3;
  localparam int AXIS_W    = 2;

  // Axis time: clamped to [-1, ONE + 1], signed.
  localparam int TW        = TIME_FRAC_BITS + 2;
  // Stored earliest time: [0, ONE], unsigned.
  localparam int ET_W      = TIME_FRAC_BITS + 1;
  // Movement and numerators are 33 bit signed; after sign fix 34 bit.
  localparam int MOV_W     = COORD_W + 1;
  localparam int NUM_W     = COORD_W + 2;
  localparam int PROD_W    = MOV_W + ET_W + 1;

  localparam int EPS_LSB   = ((1 << COORD_FRAC_BITS) + 500000) / 1000000;

  localparam logic [ET_W-1:0]   TIME_ONE    = ET_W'(1) << TIME_FRAC_BITS;
  localparam logic signed [TW-1:0] AXIS_ONE  = TW'(1) << TIME_FRAC_BITS;
  localparam logic signed [TW-1:0] AXIS_OVER = (TW'(1) << TIME_FRAC_BITS) + TW'(1);
  localparam logic signed [TW-1:0] AXIS_UNDER = '1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    PROD_W'(1) << (TIME_FRAC_BITS - 1);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_BOX  = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] coord_ax;
    logic signed [COORD_W-1:0] coord_ay;
    logic signed [COORD_W-1:0] coord_az;
    logic signed [COORD_W-1:0] coord_bx;
    logic signed [COORD_W-1:0] coord_by;
    logic signed [COORD_W-1:0] coord_bz;
    logic                      last_box;
  } item_t;

  typedef struct packed {
    logic                      hit;
    logic [HIT_TIME_W-1:0]     hit_time;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AXIS,
    S_DIV,
    S_NEXT,
    S_UPDATE,
    S_MUL,
    S_ADD,
    S_PUT
  } state_t;

  typedef struct packed {
    logic              load_seg;
    logic              start_box;
    logic              zero_check;
    logic              div_start;
    logic              fold;
    logic              update;
    logic              mul;
    logic              add;
    logic              emit;
    logic [AXIS_W-1:0] ax;
  } cmd_t;

  typedef struct packed {
    logic zero_mov;
    logic div_done;
    logic pass;
    logic last;
    logic out_free;
  } stat_t;

endpackage

@@ design/sphit_div.sv @@
// Iterative restoring divider for one slab time: floor(num * 2^T / den),
// clamped to [-1, 2^T + 1]. One quotient bit per cycle. Uses sphit_pkg.
module sphit_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [sphit_pkg::NUM_W-1:0] num,
  input  logic [sphit_pkg::MOV_W-1:0]        den,
  output logic                               done,
  output logic signed [sphit_pkg::TW-1:0]    q
);
  import sphit_pkg::*;

  localparam int STEPS = TIME_FRAC_BITS + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [NUM_W-1:0]          r;
  logic [MOV_W-1:0]          d;
  logic [TIME_FRAC_BITS:0]   quo;
  logic [CNT_W-1:0]          cnt;
  logic                      run;
  logic                      sat_lo;
  logic                      sat_hi;
  logic                      bit_q;
  logic [NUM_W-1:0]          rem;

  always_comb begin
    bit_q = r >= NUM_W'(d);
    rem   = bit_q ? r - NUM_W'(d) : r;
  end

  // Always runs the full bit count, so two dividers started together finish together;
  // a saturated quotient is overridden at the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sat_lo <= num < 0;
        sat_hi <= (num >= 0) && (NUM_W'(unsigned'(num)) >= {den, 1'b0});
        r      <= NUM_W'(unsigned'(num));
        d      <= den;
        quo    <= '0;
        run    <= 1'b1;
        cnt    <= CNT_W'(STEPS);
      end else if (run) begin
        quo <= {quo[TIME_FRAC_BITS-1:0], bit_q};
        r   <= rem << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (sat_lo) begin
      q = AXIS_UNDER;
    end else if (sat_hi || TW'(quo) > AXIS_ONE) begin
      q = AXIS_OVER;
    end else begin
      q = TW'(quo);
    end
  end

endmodule

@@ design/sphit_ctrl.sv @@
// Sequencer for the swept point / box block: walks the axes of a box test,
// the hit update and the hit point interpolation. Uses sphit_pkg.
module sphit_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 box_valid,
  input  logic                 box_func,
  output logic                 box_stall,
  input  sphit_pkg::stat_t     stat,
  output sphit_pkg::cmd_t      cmd
);
  import sphit_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [AXIS_W-1:0] ax;
  logic [AXIS_W-1:0] ax_next;
  logic              accept;

  assign box_stall = state != S_IDLE;
  assign accept    = box_valid && state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax    <= '0;
    end else begin
      state <= state_next;
      ax    <= ax_next;
    end
  end

  always_comb begin
    state_next = state;
    ax_next    = ax;
    case (state)
      S_IDLE: begin
        if (accept && box_func == FUNC_BOX) begin
          state_next = S_AXIS;
          ax_next    = '0;
        end
      end
      S_AXIS: state_next = stat.zero_mov ? S_NEXT : S_DIV;
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!stat.pass || ax == AXIS_W'(NUM_AXES - 1)) begin
          state_next = S_UPDATE;
        end else begin
          state_next = S_AXIS;
          ax_next    = ax + AXIS_W'(1);
        end
      end
      S_UPDATE: begin
        state_next = stat.last ? S_MUL : S_IDLE;
        ax_next    = '0;
      end
      S_MUL: state_next = S_ADD;
      S_ADD: begin
        if (ax == AXIS_W'(NUM_AXES - 1)) begin
          state_next = S_PUT;
        end else begin
          state_next = S_MUL;
          ax_next    = ax + AXIS_W'(1);
        end
      end
      S_PUT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.ax         = ax;
    cmd.load_seg   = accept && box_func == FUNC_LOAD;
    cmd.start_box  = accept && box_func == FUNC_BOX;
    cmd.zero_check = state == S_AXIS && stat.zero_mov;
    cmd.div_start  = state == S_AXIS && !stat.zero_mov;
    cmd.fold       = state == S_DIV && stat.div_done;
    cmd.update     = state == S_UPDATE;
    cmd.mul        = state == S_MUL;
    cmd.add        = state == S_ADD;
    cmd.emit       = state == S_PUT && stat.out_free;
  end

endmodule

@@ design/sphit_dp.sv @@
// Datapath: segment and box registers, two slab-time dividers, interval fold,
// earliest-hit store, hit point multiplier and result register.
// Uses sphit_pkg and sphit_div.
module sphit_dp (
  input  logic                clk,
  input  logic                rst,
  input  sphit_pkg::item_t    box,
  input  sphit_pkg::cmd_t     cmd,
  output sphit_pkg::stat_t    stat,
  output logic                result_valid,
  input  logic                result_stall,
  output sphit_pkg::result_t  result
);
  import sphit_pkg::*;

  logic signed [COORD_W-1:0] seg_s [NUM_AXES];
  logic signed [COORD_W-1:0] seg_e [NUM_AXES];
  logic signed [COORD_W-1:0] lo    [NUM_AXES];
  logic signed [COORD_W-1:0] hi    [NUM_AXES];
  logic signed [COORD_W-1:0] pt    [NUM_AXES];
  logic [ET_W-1:0]           earliest;
  logic                      any_hit;
  logic                      last;
  logic signed [TW-1:0]      entry;
  logic signed [TW-1:0]      exit_t;
  logic                      pass;
  logic signed [PROD_W-1:0]  prod;

  logic signed [COORD_W-1:0] s_sel;
  logic signed [NUM_W-1:0]   mov;
  logic signed [NUM_W-1:0]   num_lo;
  logic signed [NUM_W-1:0]   num_hi;
  logic                      mov_neg;
  logic signed [NUM_W-1:0]   n_lo;
  logic signed [NUM_W-1:0]   n_hi;
  logic signed [NUM_W-1:0]   d_abs;
  logic [MOV_W-1:0]          den;
  logic                      in_slab;
  logic                      done_lo;
  logic                      done_hi;
  logic signed [TW-1:0]      t_lo;
  logic signed [TW-1:0]      t_hi;
  logic signed [TW-1:0]      t_min;
  logic signed [TW-1:0]      t_max;
  logic signed [TW-1:0]      entry_n;
  logic signed [TW-1:0]      exit_n;
  logic                      upd_ok;
  logic                      out_free;
  logic signed [PROD_W-1:0]  pt_sum;

  always_comb begin
    s_sel   = seg_s[cmd.ax];
    mov     = NUM_W'(seg_e[cmd.ax]) - NUM_W'(s_sel);
    num_lo  = NUM_W'(lo[cmd.ax]) - NUM_W'(s_sel);
    num_hi  = NUM_W'(hi[cmd.ax]) - NUM_W'(s_sel);
    mov_neg = mov < 0;
    n_lo    = mov_neg ? -num_lo : num_lo;
    n_hi    = mov_neg ? -num_hi : num_hi;
    d_abs   = mov_neg ? -mov : mov;
    den     = d_abs[MOV_W-1:0];
    in_slab = s_sel >= lo[cmd.ax] && s_sel <= hi[cmd.ax];
  end

  sphit_div u_div_lo (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (n_lo),
    .den  (den),
    .done (done_lo),
    .q    (t_lo)
  );

  sphit_div u_div_hi (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (n_hi),
    .den  (den),
    .done (done_hi),
    .q    (t_hi)
  );

  always_comb begin
    t_min   = (t_lo > t_hi) ? t_hi : t_lo;
    t_max   = (t_lo > t_hi) ? t_lo : t_hi;
    entry_n = (t_min > entry) ? t_min : entry;
    exit_n  = (t_max < exit_t) ? t_max : exit_t;
    upd_ok  = pass && entry >= 0 && entry <= AXIS_ONE
              && entry <= signed'(TW'(earliest));
    out_free = !result_valid || !result_stall;
    pt_sum  = PROD_W'(seg_s[cmd.ax]) + (prod >>> TIME_FRAC_BITS);
  end

  assign stat.zero_mov = d_abs <= NUM_W'(EPS_LSB);
  assign stat.div_done = done_lo && done_hi;
  assign stat.pass     = pass;
  assign stat.last     = last;
  assign stat.out_free = out_free;

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        seg_s[i] <= '0;
        seg_e[i] <= '0;
      end
      earliest     <= TIME_ONE;
      any_hit      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load_seg) begin
        seg_s[0] <= box.coord_ax;
        seg_s[1] <= box.coord_ay;
        seg_s[2] <= box.coord_az;
        seg_e[0] <= box.coord_bx;
        seg_e[1] <= box.coord_by;
        seg_e[2] <= box.coord_bz;
        earliest <= TIME_ONE;
        any_hit  <= 1'b0;
      end
      if (cmd.update && upd_ok) begin
        earliest <= entry[ET_W-1:0];
        any_hit  <= 1'b1;
      end
      if (cmd.emit) begin
        earliest     <= TIME_ONE;
        any_hit      <= 1'b0;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.start_box) begin
      lo[0]  <= box.coord_ax;
      lo[1]  <= box.coord_ay;
      lo[2]  <= box.coord_az;
      hi[0]  <= box.coord_bx;
      hi[1]  <= box.coord_by;
      hi[2]  <= box.coord_bz;
      last   <= box.last_box;
      entry  <= '0;
      exit_t <= AXIS_ONE;
      pass   <= 1'b1;
    end
    if (cmd.zero_check) begin
      pass <= pass && in_slab;
    end
    if (cmd.fold) begin
      entry  <= entry_n;
      exit_t <= exit_n;
      pass   <= entry_n <= exit_n;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(signed'(mov[MOV_W-1:0]) * signed'({1'b0, earliest})) + ROUND_HALF;
    end
    if (cmd.add) begin
      pt[cmd.ax] <= any_hit ? pt_sum[COORD_W-1:0] : seg_e[cmd.ax];
    end
    if (cmd.emit) begin
      result.hit      <= any_hit;
      result.hit_time <= HIT_TIME_W'(earliest);
      result.hit_x    <= pt[0];
      result.hit_y    <= pt[1];
      result.hit_z    <= pt[2];
    end
  end

endmodule

@@ design/swept_point_box_earliest_hit.sv @@
// Swept point against a list of axis-aligned boxes, earliest hit. A load
// transaction (func 0) is taken in the idle state without leaving it. A box
// transaction goes through acceptance and the hit update plus, per axis that is
// tested, a slab check when the axis does not move and a division otherwise (both
// slab times come from a pair of bit-serial dividers that share one denominator);
// testing stops at the first axis that misses. The last box then interpolates the
// hit point on a single multiplier, and waits longer while the previous result is
// still held by result_stall. A finished result waits in the output register while
// new transactions are taken.
module swept_point_box_earliest_hit (
  input  logic               clk,
  input  logic               rst,
  input  logic               box_valid,
  output logic               box_stall,
  input  sphit_pkg::item_t   box,
  output logic               result_valid,
  input  logic               result_stall,
  output sphit_pkg::result_t result
);
  import sphit_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sphit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .box_valid(box_valid),
    .box_func (box.func),
    .box_stall(box_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sphit_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .box         (box),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

@@ sim/sphit_checker.sv @@
// Checker for swept_point_box_earliest_hit: watches the box and result channels,
// predicts each result from accepted box transactions and compares field by field.
// Depends on sphit_pkg.
module sphit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               box_valid,
  input  logic               box_stall,
  input  sphit_pkg::item_t   box,
  input  logic               result_valid,
  input  logic               result_stall,
  input  sphit_pkg::result_t result,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sphit_pkg::*;

  localparam longint T_ONE = longint'(1) << TIME_FRAC_BITS;
  localparam longint EPS = ((longint'(1) << COORD_FRAC_BITS) + 500000) / 1000000;

  longint seg_a [3];
  longint seg_b [3];
  longint best_time;
  bit     found;
  result_t hit_queue [$];

  assign pending = hit_queue.size();

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint slab_time(longint num, longint mov);
    longint q;
    if (mov < 0) begin
      num = -num;
      mov = -mov;
    end
    q = div_floor(num * T_ONE, mov);
    if (q < 0) q = -1;
    if (q > T_ONE) q = T_ONE + 1;
    return q;
  endfunction

  task automatic predict_box(input item_t it);
    longint lo [3];
    longint hi [3];
    longint entry, leave, s, mov, t0, t1, tmp, p;
    bit pass;
    result_t r;
    lo[0] = it.coord_ax; lo[1] = it.coord_ay; lo[2] = it.coord_az;
    hi[0] = it.coord_bx; hi[1] = it.coord_by; hi[2] = it.coord_bz;
    if (it.func == FUNC_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        seg_a[i] = lo[i];
        seg_b[i] = hi[i];
      end
      best_time = T_ONE;
      found = 0;
      return;
    end
    entry = 0;
    leave = T_ONE;
    pass = 1;
    for (int i = 0; i < 3 && pass; i++) begin
      s = seg_a[i];
      mov = seg_b[i] - s;
      if ((mov < 0 ? -mov : mov) <= EPS) begin
        pass = (s >= lo[i] && s <= hi[i]);
      end else begin
        t0 = slab_time(lo[i] - s, mov);
        t1 = slab_time(hi[i] - s, mov);
        if (t0 > t1) begin
          tmp = t0; t0 = t1; t1 = tmp;
        end
        if (t0 > entry) entry = t0;
        if (t1 < leave) leave = t1;
        pass = (entry <= leave);
      end
    end
    if (pass && entry >= 0 && entry <= T_ONE && entry <= best_time) begin
      best_time = entry;
      found = 1;
    end
    if (!it.last_box) return;
    r.hit = found;
    r.hit_time = HIT_TIME_W'(best_time);
    for (int i = 0; i < 3; i++) begin
      p = seg_b[i];
      if (found)
        p = seg_a[i] + div_floor((seg_b[i] - seg_a[i]) * best_time + T_ONE / 2, T_ONE);
      case (i)
        0: r.hit_x = COORD_W'(p);
        1: r.hit_y = COORD_W'(p);
        default: r.hit_z = COORD_W'(p);
      endcase
    end
    hit_queue.push_back(r);
    best_time = T_ONE;
    found = 0;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    hits_seen = 0;
    for (int i = 0; i < 3; i++) begin
      seg_a[i] = 0;
      seg_b[i] = 0;
    end
    best_time = T_ONE;
    found = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (box_valid && !box_stall) predict_box(box);
      if (result_valid && !result_stall) begin
        results_seen++;
        if (hit_queue.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          want = hit_queue.pop_front();
          if (want.hit) hits_seen++;
          if (result.hit !== want.hit) report("hit", result.hit, want.hit);
          if (result.hit_time !== want.hit_time)
            report("hit_time", result.hit_time, want.hit_time);
          if (result.hit_x !== want.hit_x) report("hit_x", result.hit_x, want.hit_x);
          if (result.hit_y !== want.hit_y) report("hit_y", result.hit_y, want.hit_y);
          if (result.hit_z !== want.hit_z) report("hit_z", result.hit_z, want.hit_z);
        end
      end
    end
  end
endmodule

@@ sim/swept_point_box_earliest_hit_tb.sv @@
// Top of the testbench for swept_point_box_earliest_hit: clock, reset, stimulus,
// idling and verdict. Depends on sphit_pkg, sphit_checker and the block.
module swept_point_box_earliest_hit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sphit_pkg::*;

  localparam int WATCHDOG = 20000;

  logic    clk = 0;
  logic    rst = 1;
  logic    box_valid = 0;
  logic    box_stall;
  item_t   box = '0;
  logic    result_valid;
  logic    result_stall = 0;
  result_t result;
  int      fail_count, pending, results_seen, hits_seen;
  int      idle_pct = 36;
  int      sent = 0;
  int      quiet = 0;

  swept_point_box_earliest_hit dut (
    .clk(clk), .rst(rst), .box_valid(box_valid), .box_stall(box_stall), .box(box),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  sphit_checker chk (
    .clk(clk), .rst(rst), .box_valid(box_valid), .box_stall(box_stall), .box(box),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .hits_seen(hits_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) result_stall <= ($urandom_range(99) < idle_pct);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((box_valid && !box_stall) || (result_valid && !result_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("watchdog expired");
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [31:0] any_coord();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(40 << 16)) - (20 << 16);
    endcase
  endfunction

  // small coordinates near the segment, so boxes are often hit
  function automatic logic signed [31:0] near(input int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // valid stays high after acceptance until the next idle cycle or the next item
  task automatic send(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      box_valid <= 0;
      @(posedge clk);
    end
    box <= it;
    box_valid <= 1;
    @(posedge clk);
    while (box_stall) @(posedge clk);
    sent++;
  endtask

  function automatic item_t mk(input logic f, input logic signed [31:0] ax, ay, az, bx, by,
                               bz, input logic l);
    item_t it;
    it.func = f;
    it.coord_ax = ax; it.coord_ay = ay; it.coord_az = az;
    it.coord_bx = bx; it.coord_by = by; it.coord_bz = bz;
    it.last_box = l;
    return it;
  endfunction

  task automatic random_box(input logic l);
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    for (int i = 0; i < 3; i++) begin
      a[i] = near(12 << 16);
      b[i] = a[i] + $signed($urandom_range(6 << 16));
      if ($urandom_range(15) == 0) b[i] = a[i] - 1;
      if ($urandom_range(15) == 0) begin
        a[i] = any_coord();
        b[i] = any_coord();
      end
    end
    send(mk(FUNC_BOX, a[0], a[1], a[2], b[0], b[1], b[2], l));
  endtask

  task automatic random_load();
    logic signed [31:0] s [3];
    logic signed [31:0] e [3];
    for (int i = 0; i < 3; i++) begin
      s[i] = near(16 << 16);
      e[i] = near(16 << 16);
      if ($urandom_range(4) == 0) e[i] = s[i];
      if ($urandom_range(10) == 0) s[i] = any_coord();
      if ($urandom_range(10) == 0) e[i] = any_coord();
    end
    send(mk(FUNC_LOAD, s[0], s[1], s[2], e[0], e[1], e[2], $urandom_range(1)));
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // box before any load uses the all-zero segment
    send(mk(FUNC_BOX, -1, -1, -1, 1, 1, 1, 1));
    send(mk(FUNC_BOX, 1, 1, 1, 2, 2, 2, 1));
    // load with last_box set gives no result
    send(mk(FUNC_LOAD, 0, 0, 0, 10 << 16, 0, 0, 1));
    send(mk(FUNC_BOX, 4 << 16, -1, -1, 6 << 16, 1, 1, 0));
    // tie at equal entry, then inverted box, stationary axis miss, earlier box
    send(mk(FUNC_BOX, 4 << 16, -5, -5, 9 << 16, 5, 5, 0));
    send(mk(FUNC_BOX, 2 << 16, 3, 3, 1 << 16, 5, 5, 0));
    send(mk(FUNC_BOX, 1 << 16, 1, -1, 2 << 16, 5, 1, 0));
    send(mk(FUNC_BOX, 1 << 16, -1, -1, 3 << 16, 1, 1, 1));
    // box already containing start: time 0; box beyond end: miss
    send(mk(FUNC_BOX, -1, -1, -1, 1, 1, 1, 1));
    send(mk(FUNC_BOX, 11 << 16, -1, -1, 12 << 16, 1, 1, 1));
    // extreme coordinates and reversed movement
    send(mk(FUNC_LOAD, 32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff,
            -1, 0));
    send(mk(FUNC_BOX, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
            32'sh7fffffff, 32'sh7fffffff, 0));
    send(mk(FUNC_BOX, 32'sh7fffffff, 32'sh80000000, -1, 32'sh7fffffff, 32'sh7fffffff,
            0, 1));
    send(mk(FUNC_BOX, '1, '1, '1, '1, '1, '1, 1));
    // exit exactly at 1.0
    send(mk(FUNC_LOAD, 0, 0, 0, 3, 7, -5, 0));
    send(mk(FUNC_BOX, 3, 7, -5, 3, 7, -5, 1));

    n = 0;
    while (sent < 2000) begin
      if (n == 300) idle_pct = 0;
      if (n == 500) idle_pct = 36;
      n++;
      if ($urandom_range(9) == 0) begin
        send(mk($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom_range(1)));
      end else begin
        random_load();
        repeat ($urandom_range(4)) random_box(0);
        random_box($urandom_range(7) != 0);
      end
    end
    box_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d box transactions, checked %0d results (%0d hits)",
             sent, results_seen, hits_seen);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
